// ===== hw/rtl/gjs_pkg.sv =====
// Package for the Gauss-Jordan solver: fixed-point helpers, controller states
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package gjs_pkg;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_FWD_RD,       // read pivot of column i
		ST_FWD_CHK,      // test pivot of column i
		ST_SWP_SRCH,     // read row j column i
		ST_SWP_TEST,
		ST_SWP_RD,       // swap row i and row j, one column per pass
		ST_SWP_WR,
		ST_ELM_RD,       // read target and pivot in column c
		ST_ELM_DIV,      // run divider for the ratio
		ST_ELM_COL,      // read row p and row j at column z
		ST_ELM_MUL,
		ST_ELM_WR,
		ST_BWD_RD,
		ST_BWD_CHK,
		ST_FIN_RD,
		ST_FIN_DIV,
		ST_EMIT,
		ST_FAIL
	} gjs_state_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_PIVOT,     // read store[a_row][a_col] into the pivot register
		RD_TARGET,    // read store[b_row][b_col] into the target register
		RD_PAIR       // read both a and b entries
	} gjs_rd_t;

	typedef struct packed {
		gjs_rd_t    rd;
		logic [4:0] a_row;
		logic [5:0] a_col;
		logic [4:0] b_row;
		logic [5:0] b_col;
		logic       div_start;    // start divider on target/pivot
		logic       neg_ratio;    // latch negated quotient as ratio
		logic       mul;          // product of pivot entry and ratio
		logic       wr_sum;       // write target + product to b
		logic       wr_zero;      // write zero to b
		logic       wr_swap;      // write a into b and b into a
		logic       load_wr;      // write load coefficient
		logic [4:0] load_row;
		logic [5:0] load_col;
	} gjs_cmd_t;

	typedef struct packed {
		logic pivot_zero;
		logic target_zero;
		logic div_done;
	} gjs_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)       return Q_MAX;
		else if (v < -66'sd2147483648) return Q_MIN;
		else                           return v[31:0];
	endfunction

endpackage

// ===== hw/rtl/gjs_div.sv =====
// Radix-2 restoring divider for Q16.16 quotients, truncating toward zero
// with saturation. One quotient bit per cycle. Uses gjs_pkg.
module gjs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  num,
	input  logic signed [31:0]  den,
	output logic                done,
	output logic signed [31:0]  quo
);
	import gjs_pkg::*;

	localparam int NW = 48; // |num| * 2^16 fits 48 bits

	logic [NW-1:0] rem_q;
	logic [NW-1:0] dvd_q;
	logic [31:0]   den_q;
	logic [NW-1:0] q_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          zero_q;
	logic [NW:0]   trial;
	logic [NW-1:0] rem_sh;
	logic signed [65:0] sq;

	assign rem_sh = {rem_q[NW-2:0], dvd_q[NW-1]};
	assign trial  = {1'b0, rem_sh} - {{(NW-31){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			q_q    <= '0;
			dvd_q  <= {(num[31] ? 32'(-num) : 32'(num)), 16'h0};
			den_q  <= den[31] ? 32'(-den) : 32'(den);
			neg_q  <= num[31] ^ den[31];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({18'h0, q_q}) : $signed({18'h0, q_q});
		quo = zero_q ? '0 : sat32(sq);
	end
endmodule

// ===== hw/rtl/gjs_datapath.sv =====
// Datapath of the solver: matrix memory, pivot/target registers, divider,
// multiplier and saturating adder. Driven by gjs_cmd_t. Uses gjs_pkg, gjs_div.
module gjs_datapath #(
	parameter int MAX_N = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gjs_pkg::gjs_cmd_t  cmd,
	input  logic signed [31:0] coefficient,
	output gjs_pkg::gjs_sts_t  sts,
	output logic signed [31:0] result
);
	import gjs_pkg::*;

	localparam int NC = MAX_N + 1;
	localparam int RW = $clog2(MAX_N);
	localparam int CW = $clog2(NC);
	localparam int DEPTH = MAX_N * NC;
	localparam int AW = $clog2(DEPTH);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] a_q, b_q, ratio_q, prod_s1;
	logic [AW-1:0]      a_addr, b_addr, ld_addr;
	logic               dv_done;
	logic signed [31:0] dv_quo;
	logic signed [63:0] full;
	logic signed [63:0] trunc;

	assign a_addr  = AW'(cmd.a_row[RW-1:0] * NC + cmd.a_col[CW-1:0]);
	assign b_addr  = AW'(cmd.b_row[RW-1:0] * NC + cmd.b_col[CW-1:0]);
	assign ld_addr = AW'(cmd.load_row[RW-1:0] * NC + cmd.load_col[CW-1:0]);

	// one read port per operand, one write port at a time (two for swap)
	always_ff @(posedge clk) begin
		if (cmd.rd == RD_PIVOT || cmd.rd == RD_PAIR) a_q <= mem[a_addr];
		if (cmd.rd == RD_TARGET || cmd.rd == RD_PAIR) b_q <= mem[b_addr];
		if (cmd.load_wr) mem[ld_addr] <= coefficient;
		else if (cmd.wr_zero) mem[b_addr] <= '0;
		else if (cmd.wr_sum) mem[b_addr] <= sat32(66'(b_q) + 66'(prod_s1));
		else if (cmd.wr_swap) begin
			mem[b_addr] <= a_q;
			mem[a_addr] <= b_q;
		end
		if (cmd.neg_ratio) ratio_q <= (dv_quo == Q_MIN) ? Q_MAX : -dv_quo;
		if (cmd.mul) prod_s1 <= sat32(66'(trunc));
	end

	assign full  = a_q * ratio_q;
	// divide by 2^16 truncating toward zero
	assign trunc = (full + (full[63] ? 64'sd65535 : 64'sd0)) >>> 16;

	gjs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (b_q),
		.den   (a_q),
		.done  (dv_done),
		.quo   (dv_quo)
	);

	assign sts.pivot_zero  = (a_q == '0);
	assign sts.target_zero = (b_q == '0);
	assign sts.div_done    = dv_done;
	assign result          = dv_quo;
endmodule

// ===== hw/rtl/gjs_ctrl.sv =====
// Controller of the solver: load counter, elimination sequencer, solution
// buffer and output register. Commands gjs_datapath. Uses gjs_pkg.
module gjs_ctrl #(
	parameter int MAX_N = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  gjs_pkg::gjs_sts_t  sts,
	input  logic signed [31:0] quo,
	output gjs_pkg::gjs_cmd_t  cmd,
	input  logic               out_stall,
	output logic               out_valid,
	output logic signed [31:0] solution_value,
	output logic [2:0]         solution_index,
	output logic               last_result,
	output logic               no_unique
);
	import gjs_pkg::*;

	gjs_state_t state_q, state_d;
	logic [3:0] size_q;
	logic [4:0] n;
	logic [4:0] ld_row_q, ld_col_q;
	logic [4:0] i_q, j_q, z_q, k_q;
	logic       bwd_q;
	logic signed [31:0] sol_q [MAX_N];
	logic       accept, ovld_q, ofail_q, oadv;
	logic       lastcoef;
	logic       start_q;
	logic       div_go;

	always_comb begin
		if (size_q == 4'd0) n = 5'd1;
		else if (32'(size_q) > MAX_N) n = 5'(MAX_N);
		else n = {1'b0, size_q};
	end

	assign in_stall = (state_q != ST_LOAD);
	assign accept   = in_valid && !in_stall;
	assign lastcoef = (ld_row_q == n - 5'd1) && (ld_col_q == n);
	assign oadv     = !ovld_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:     if (accept && lastcoef)
				state_d = (n == 5'd1) ? ST_BWD_RD : ST_FWD_RD;
			ST_FWD_RD:   state_d = ST_FWD_CHK;
			ST_FWD_CHK:  state_d = sts.pivot_zero ? ST_SWP_SRCH : ST_ELM_RD;
			ST_SWP_SRCH: state_d = (j_q >= n) ? ST_FAIL : ST_SWP_TEST;
			ST_SWP_TEST: state_d = sts.target_zero ? ST_SWP_SRCH : ST_SWP_RD;
			ST_SWP_RD:   state_d = ST_SWP_WR;
			ST_SWP_WR:   state_d = (z_q == n) ? ST_FWD_RD : ST_SWP_RD;
			ST_ELM_RD:   state_d = ST_ELM_DIV;
			ST_ELM_DIV:  if (sts.div_done) state_d = ST_ELM_COL;
			ST_ELM_COL:  state_d = ST_ELM_MUL;
			ST_ELM_MUL:  state_d = ST_ELM_WR;
			ST_ELM_WR: begin
				if (z_q != n) state_d = ST_ELM_COL;
				else if (!bwd_q) begin
					if (j_q + 5'd1 < n) state_d = ST_ELM_RD;
					else if (i_q + 5'd2 < n) state_d = ST_FWD_RD;
					else state_d = ST_BWD_RD;
				end else begin
					if (j_q + 5'd1 < i_q) state_d = ST_ELM_RD;
					else state_d = ST_BWD_RD;
				end
			end
			ST_BWD_RD:   state_d = ST_BWD_CHK;
			ST_BWD_CHK: begin
				if (i_q == 5'd0) state_d = ST_FIN_RD;
				else if (sts.pivot_zero) state_d = ST_FAIL;
				else state_d = ST_ELM_RD;
			end
			ST_FIN_RD:   state_d = ST_FIN_DIV;
			ST_FIN_DIV: begin
				if (sts.pivot_zero) state_d = ST_FAIL;
				else if (sts.div_done)
					state_d = (k_q + 5'd1 == n) ? ST_EMIT : ST_FIN_RD;
			end
			ST_EMIT, ST_FAIL:
				if (oadv && k_q + 5'd1 == n) state_d = ST_LOAD;
			default:     state_d = ST_LOAD;
		endcase
	end

	// commands per state; in the backward pass the pivot row i_q counts down, and at row 0 the final divides start
	always_comb begin
		cmd = '0;
		cmd.div_start = div_go;
		cmd.load_row = ld_row_q;
		cmd.load_col = {1'b0, ld_col_q};
		unique case (state_q)
			ST_LOAD: cmd.load_wr = accept;
			ST_FWD_RD, ST_BWD_RD: begin
				cmd.rd = RD_PIVOT; cmd.a_row = i_q; cmd.a_col = {1'b0, i_q};
			end
			ST_FWD_CHK, ST_BWD_CHK: ;
			ST_SWP_SRCH: begin
				cmd.rd = RD_TARGET; cmd.b_row = j_q; cmd.b_col = {1'b0, i_q};
			end
			ST_SWP_TEST: ;
			ST_SWP_RD: begin
				cmd.rd = RD_PAIR;
				cmd.a_row = i_q; cmd.a_col = {1'b0, z_q};
				cmd.b_row = j_q; cmd.b_col = {1'b0, z_q};
			end
			ST_SWP_WR: begin
				cmd.wr_swap = 1'b1;
				cmd.a_row = i_q; cmd.a_col = {1'b0, z_q};
				cmd.b_row = j_q; cmd.b_col = {1'b0, z_q};
			end
			ST_ELM_RD: begin
				cmd.rd = RD_PAIR;
				cmd.a_row = i_q; cmd.a_col = {1'b0, i_q};
				cmd.b_row = j_q; cmd.b_col = {1'b0, i_q};
			end
			ST_ELM_DIV: begin
				cmd.neg_ratio = sts.div_done;
			end
			ST_ELM_COL: begin
				cmd.rd = RD_PAIR;
				cmd.a_row = i_q; cmd.a_col = {1'b0, z_q};
				cmd.b_row = j_q; cmd.b_col = {1'b0, z_q};
			end
			ST_ELM_MUL: cmd.mul = 1'b1;
			ST_ELM_WR: begin
				cmd.b_row = j_q; cmd.b_col = {1'b0, z_q};
				if (z_q == i_q) cmd.wr_zero = 1'b1;
				else cmd.wr_sum = 1'b1;
			end
			ST_FIN_RD: begin
				cmd.rd = RD_PAIR;
				cmd.a_row = k_q; cmd.a_col = {1'b0, k_q};
				cmd.b_row = k_q; cmd.b_col = {1'b0, n};
			end
			ST_FIN_DIV, ST_EMIT, ST_FAIL: ;
			default: ;
		endcase
	end

	// divider start is registered from the read state and pulses once the operands are latched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 1'b0;
		else start_q <= (state_q == ST_ELM_RD) || (state_q == ST_FIN_RD);
	end

	assign div_go = start_q && !((state_q == ST_FIN_DIV) && sts.pivot_zero);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			size_q   <= 4'd8;
			ld_row_q <= '0;
			ld_col_q <= '0;
			i_q      <= '0;
			j_q      <= '0;
			z_q      <= '0;
			k_q      <= '0;
			bwd_q    <= 1'b0;
			ovld_q   <= 1'b0;
			ofail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				size_q   <= cfg_wdata;
				ld_row_q <= '0;
				ld_col_q <= '0;
			end else if (accept) begin
				if (ld_col_q == n) begin
					ld_col_q <= '0;
					ld_row_q <= lastcoef ? 5'd0 : ld_row_q + 5'd1;
				end else ld_col_q <= ld_col_q + 5'd1;
			end
			if (oadv) ovld_q <= (state_q == ST_EMIT) || (state_q == ST_FAIL);
			unique case (state_q)
				ST_LOAD: if (accept && lastcoef) begin
					i_q   <= 5'd0;
					bwd_q <= (n == 5'd1);
					k_q   <= '0;
				end
				ST_FWD_RD: ;
				ST_FWD_CHK: begin
					j_q <= i_q + 5'd1;
				end
				ST_SWP_SRCH: if (j_q >= n) k_q <= '0;
				ST_SWP_TEST: begin
					if (sts.target_zero) j_q <= j_q + 5'd1;
					else z_q <= '0;
				end
				ST_SWP_RD: ;
				ST_SWP_WR: z_q <= z_q + 5'd1;
				ST_ELM_RD: z_q <= '0;
				ST_ELM_DIV: ;
				ST_ELM_COL: ;
				ST_ELM_MUL: ;
				ST_ELM_WR: begin
					if (z_q != n) z_q <= z_q + 5'd1;
					else begin
						z_q <= '0;
						if (!bwd_q) begin
							if (j_q + 5'd1 < n) j_q <= j_q + 5'd1;
							else if (i_q + 5'd2 < n) i_q <= i_q + 5'd1;
							else begin
								bwd_q <= 1'b1;
								i_q   <= n - 5'd1;
							end
						end else begin
							if (j_q + 5'd1 < i_q) j_q <= j_q + 5'd1;
							else i_q <= i_q - 5'd1;
						end
					end
				end
				ST_BWD_RD: ;
				ST_BWD_CHK: begin
					j_q <= '0;
					k_q <= '0;
				end
				ST_FIN_RD: ;
				ST_FIN_DIV: begin
					if (sts.pivot_zero) k_q <= '0;
					else if (sts.div_done) begin
						sol_q[k_q[$clog2(MAX_N)-1:0]] <= quo;
						k_q <= (k_q + 5'd1 == n) ? 5'd0 : k_q + 5'd1;
					end
				end
				ST_EMIT, ST_FAIL: if (oadv) begin
					ofail_q <= (state_q == ST_FAIL);
					solution_value <= (state_q == ST_FAIL) ? '0 :
						sol_q[k_q[$clog2(MAX_N)-1:0]];
					solution_index <= k_q[2:0];
					last_result    <= (k_q + 5'd1 == n);
					k_q <= (k_q + 5'd1 == n) ? 5'd0 : k_q + 5'd1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = ovld_q;
	assign no_unique = ofail_q;

`ifndef SYNTHESIS
	a_stall_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !in_stall) else $error("load stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(solution_value)))
		else $error("output not held");
	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !accept) else $error("accept while busy");
`endif
endmodule

// ===== hw/rtl/gauss_jordan_solver.sv =====
// Gauss-Jordan solver, Q16.16. Loading accepts one coefficient per cycle, n(n+1) in all.
// The solve runs n(n-1) row clears (read, divide, then read, multiply and write per
// column), n final divides, a read and a check per pivot and a read and a test per
// row searched, plus a read and a write per column of a row swap. Results leave one per
// cycle unless stalled; input stalls from the last coefficient until the last result
// enters the output register. arst_n clears control state; matrix memory is not cleared.
module gauss_jordan_solver #(
	parameter int MAX_N = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] coefficient,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] solution_value,
	output logic [2:0]         solution_index,
	output logic               last_result,
	output logic               no_unique
);
	import gjs_pkg::*;

	gjs_cmd_t cmd;
	gjs_sts_t sts;
	logic signed [31:0] quo;

	gjs_ctrl #(.MAX_N(MAX_N)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .sts(sts), .quo(quo),
		.cmd(cmd), .out_stall(out_stall), .out_valid(out_valid),
		.solution_value(solution_value), .solution_index(solution_index),
		.last_result(last_result), .no_unique(no_unique)
	);

	gjs_datapath #(.MAX_N(MAX_N)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .coefficient(coefficient),
		.sts(sts), .result(quo)
	);
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for gauss_jordan_solver: loads augmented matrices, predicts the
// Q16.16 solution in a behavioral solver and checks every transfer.
// Depends on the solver RTL in hw/rtl.
module tb;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [3:0]         cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] coefficient;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] solution_value;
	logic [2:0]         solution_index;
	logic               last_result;
	logic               no_unique;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         index;
		logic               last;
		logic               nu;
	} solution_t;

	solution_t solution_q[$];
	int        n_err;
	bit        sink_idle_en;
	bit        src_idle_en;
	bit        sink_hold;
	logic [3:0] size_reg;
	int         load_pos;
	logic signed [31:0] mat[8][9];

	gauss_jordan_solver u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
		.out_valid(out_valid), .out_stall(out_stall),
		.solution_value(solution_value), .solution_index(solution_index),
		.last_result(last_result), .no_unique(no_unique)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic signed [31:0] sat(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return sat(p / 66'sd65536);
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [65:0] p;
		if (b == 0) return 0;
		p = 66'(a) * 66'sd65536;
		return sat(p / 66'(b));
	endfunction

	function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat(66'(a) + 66'(b));
	endfunction

	function automatic int eff_size();
		if (size_reg == 0) return 1;
		if (size_reg > 8) return 8;
		return size_reg;
	endfunction

	task automatic clear_row(input int n, input int j, input int p, input int c);
		logic signed [31:0] f;
		f = sat(-66'(fx_div(mat[j][c], mat[p][c])));
		for (int z = 0; z <= n; z++)
			mat[j][z] = fx_add(mat[j][z], fx_mul(mat[p][z], f));
		mat[j][c] = 0;
	endtask

	task automatic eliminate(input int n, output bit ok,
		output logic signed [31:0] sol[8]);
		bit found;
		logic signed [31:0] t;
		ok = 0;
		for (int k = 0; k < 8; k++) sol[k] = 0;
		for (int i = 0; i + 1 < n; i++) begin
			if (mat[i][i] == 0) begin
				found = 0;
				for (int j = i + 1; j < n && !found; j++) begin
					if (mat[j][i] != 0) begin
						for (int z = 0; z < 9; z++) begin
							t = mat[i][z]; mat[i][z] = mat[j][z]; mat[j][z] = t;
						end
						found = 1;
					end
				end
				if (!found) return;
			end
			for (int j = i + 1; j < n; j++) clear_row(n, j, i, i);
		end
		for (int i = n - 1; i >= 1; i--) begin
			if (mat[i][i] == 0) return;
			for (int j = 0; j < i; j++) clear_row(n, j, i, i);
		end
		for (int i = 0; i < n; i++) begin
			if (mat[i][i] == 0) return;
			sol[i] = fx_div(mat[i][n], mat[i][i]);
		end
		ok = 1;
	endtask

	// Store one coefficient; on the last one, push the predicted solution.
	task automatic predict_coefficient(input logic signed [31:0] c);
		int n;
		bit ok;
		logic signed [31:0] sol[8];
		solution_t s;
		n = eff_size();
		if (load_pos >= n * (n + 1)) load_pos = 0;
		mat[load_pos / (n + 1)][load_pos % (n + 1)] = c;
		load_pos++;
		if (load_pos < n * (n + 1)) return;
		load_pos = 0;
		eliminate(n, ok, sol);
		for (int k = 0; k < n; k++) begin
			s.value = ok ? sol[k] : 32'sd0;
			s.index = k[2:0];
			s.last  = (k + 1 == n);
			s.nu    = !ok;
			solution_q.push_back(s);
		end
	endtask

	// Valid stays high after a transfer; a gap, a wait or a size write drops it.
	task automatic send_coefficient(input logic signed [31:0] c);
		int gap;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1;
		coefficient <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_coefficient(c);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (solution_q.size() != 0) @(posedge clk);
		repeat (40000) @(posedge clk);
	endtask

	task automatic write_size(input logic [3:0] v);
		in_valid  <= 0;
		cfg_we    <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 0;
		size_reg = v;
		load_pos = 0;
	endtask

	function automatic logic signed [31:0] rand_coef(input int mode);
		case (mode)
			0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1: return $urandom_range(0, 3) == 0 ? 32'sd0 : 32'($urandom);
			default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	task automatic send_matrix(input int mode);
		int n;
		n = eff_size();
		for (int k = 0; k < n * (n + 1); k++) send_coefficient(rand_coef(mode));
	endtask

	// Diagonal system with a known right-hand side, and extreme values.
	task automatic test_directed();
		write_size(4'd2);
		send_coefficient(32'sh10000); send_coefficient(0); send_coefficient(32'sh30000);
		send_coefficient(0); send_coefficient(32'sh20000); send_coefficient(32'sh7fffffff);
		// zero pivot that needs a row swap
		send_coefficient(0); send_coefficient(32'sh10000); send_coefficient(32'sh50000);
		send_coefficient(32'sh20000); send_coefficient(0); send_coefficient(32'sh80000000);
		// singular: no swap row
		send_coefficient(0); send_coefficient(32'sh10000); send_coefficient(1);
		send_coefficient(0); send_coefficient(32'sh20000); send_coefficient(-1);
		wait_drained();
		// single unknown, including a zero diagonal
		write_size(4'd1);
		send_coefficient(32'sh80000000); send_coefficient(32'sh7fffffff);
		send_coefficient(0); send_coefficient(32'sh10000);
		send_coefficient(32'sh10000); send_coefficient(32'shffffffff);
		wait_drained();
	endtask

	// Size zero acts as one, above eight as eight; a write mid-load restarts.
	task automatic test_size_limits();
		write_size(4'd0);
		send_matrix(2);
		wait_drained();
		write_size(4'd3);
		send_coefficient(32'sh10000); send_coefficient(32'sh20000);
		wait_drained();
		write_size(4'd15);
		send_matrix(0);
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering coefficients.
	task automatic test_back_pressure();
		write_size(4'd2);
		sink_hold = 1;
		for (int m = 0; m < 4; m++) send_matrix(2);
		sink_hold = 0;
		wait_drained();
	endtask

	task automatic test_random();
		int count;
		count = 0;
		while (count < 50) begin
			write_size($urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 4)));
			for (int m = 0; m < 3; m++) begin
				send_matrix($urandom_range(0, 5) == 0 ? 1 : 2);
				count += eff_size() * (eff_size() + 1);
			end
			wait_drained();
		end
	endtask

	task automatic test_no_idle();
		src_idle_en  = 0;
		sink_idle_en = 0;
		write_size(4'd3);
		for (int m = 0; m < 3; m++) send_matrix(2);
		wait_drained();
	endtask

	initial begin
		arst_n       = 0;
		cfg_we       = 0;
		cfg_wdata    = 0;
		in_valid     = 0;
		coefficient  = 0;
		n_err        = 0;
		size_reg     = 4'd8;
		load_pos     = 0;
		src_idle_en  = 1;
		sink_idle_en = 1;
		sink_hold    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_size_limits();
		test_back_pressure();
		test_random();
		test_no_idle();
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver stall: random bursts, plus a long hold counted here.
	initial begin
		int hold_cnt;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				out_stall <= 1;
				for (hold_cnt = 0; hold_cnt < 3000 && sink_hold; hold_cnt++)
					@(posedge clk);
				out_stall <= 0;
				while (sink_hold) @(posedge clk);
			end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Check each solution transfer against the oldest prediction.
	always @(posedge clk) begin
		solution_t exp_s;
		if (arst_n && out_valid && !out_stall) begin
			if (solution_q.size() == 0) begin
				$display("%0t unexpected transfer: value %h index %0d",
					$time, solution_value, solution_index);
				n_err++;
			end else begin
				exp_s = solution_q.pop_front();
				if (solution_value !== exp_s.value || solution_index !== exp_s.index ||
					last_result !== exp_s.last || no_unique !== exp_s.nu) begin
					$display("%0t mismatch: expected %h/%0d/%b/%b actual %h/%0d/%b/%b",
						$time, exp_s.value, exp_s.index, exp_s.last, exp_s.nu,
						solution_value, solution_index, last_result, no_unique);
					n_err++;
				end
			end
		end
	end

endmodule

// ===== filelist.f =====
hw/rtl/gjs_pkg.sv
hw/rtl/gjs_div.sv
hw/rtl/gjs_datapath.sv
hw/rtl/gjs_ctrl.sv
hw/rtl/gauss_jordan_solver.sv
sim/tb.sv
